>>> rtl/zoom_pan_source_address_generator_top_defines.svh
// assertion macros for the zoom and pan source address generator
`ifndef ZOOM_PAN_SOURCE_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define ZOOM_PAN_SOURCE_ADDRESS_GENERATOR_TOP_DEFINES_SVH

// checked only outside reset
`define ZPSAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ZPSAG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/zpsag_pkg.sv
// shared types and constants of the zoom and pan source address generator
`default_nettype none

package zpsag_pkg;

  // saturation limits
  localparam int MAX_IMAGE_DIM   = 4096;
  localparam int MAX_VIEW_WIDTH  = 512;
  localparam int MAX_VIEW_HEIGHT = 256;
  localparam int INVZ_MIN        = 8192;
  localparam int INVZ_MAX        = 262144;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 19;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VIEW_WIDTH     = 3'd0,
    REG_VIEW_HEIGHT    = 3'd1,
    REG_IMAGE_WIDTH    = 3'd2,
    REG_IMAGE_HEIGHT   = 3'd3,
    REG_INVERSE_ZOOM   = 3'd4,
    REG_PAN_HORIZONTAL = 3'd5,
    REG_PAN_VERTICAL   = 3'd6
  } cfg_reg_t;

  // register file contents, already saturated
  typedef struct packed {
    logic [9:0]         view_width;
    logic [8:0]         view_height;
    logic [12:0]        image_width;
    logic [12:0]        image_height;
    logic [18:0]        inverse_zoom;
    logic signed [13:0] pan_horizontal;
    logic signed [13:0] pan_vertical;
  } cfg_t;

  // per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

>>> rtl/zpsag_cfg.sv
// configuration register file with saturation on write
`default_nettype none

module zpsag_cfg (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [zpsag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [zpsag_pkg::CFG_DATA_W-1:0]  cfg_data,
  output zpsag_pkg::cfg_t                   cfg
);
  import zpsag_pkg::*;

  function automatic logic [31:0] sat_u(logic [31:0] raw, int lo, int hi);
    logic [31:0] r;
    begin
      r = raw;
      if (int'(raw) < lo) r = 32'(lo);
      if (int'(raw) > hi) r = 32'(hi);
      return r;
    end
  endfunction

  function automatic logic signed [13:0] sat_pan(logic [13:0] raw);
    logic signed [31:0] s;
    begin
      s = 32'(signed'(raw));
      if (s < -MAX_IMAGE_DIM) s = -MAX_IMAGE_DIM;
      if (s > MAX_IMAGE_DIM)  s = MAX_IMAGE_DIM;
      return 14'(s);
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_width     <= 10'(sat_u(32'd456, 1, MAX_VIEW_WIDTH));
      cfg.view_height    <= 9'(sat_u(32'd190, 1, MAX_VIEW_HEIGHT));
      cfg.image_width    <= '0;
      cfg.image_height   <= '0;
      cfg.inverse_zoom   <= 19'd65536;
      cfg.pan_horizontal <= '0;
      cfg.pan_vertical   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEW_WIDTH:
          cfg.view_width <= 10'(sat_u(32'(cfg_data[9:0]), 1, MAX_VIEW_WIDTH));
        REG_VIEW_HEIGHT:
          cfg.view_height <= 9'(sat_u(32'(cfg_data[8:0]), 1, MAX_VIEW_HEIGHT));
        REG_IMAGE_WIDTH:
          cfg.image_width <= 13'(sat_u(32'(cfg_data[12:0]), 0, MAX_IMAGE_DIM));
        REG_IMAGE_HEIGHT:
          cfg.image_height <= 13'(sat_u(32'(cfg_data[12:0]), 0, MAX_IMAGE_DIM));
        REG_INVERSE_ZOOM:
          cfg.inverse_zoom <= 19'(sat_u(32'(cfg_data), INVZ_MIN, INVZ_MAX));
        REG_PAN_HORIZONTAL:
          cfg.pan_horizontal <= sat_pan(cfg_data[13:0]);
        REG_PAN_VERTICAL:
          cfg.pan_vertical <= sat_pan(cfg_data[13:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/zpsag_axis.sv
// one axis of the coordinate map: offset, scale, translate and range check
`default_nettype none

module zpsag_axis #(
  parameter int V_W = 9
) (
  input  wire                        clk,
  input  wire  zpsag_pkg::stage_en_t en,
  input  wire  [V_W-1:0]             v,
  input  wire  [V_W:0]               vdim,
  input  wire  [12:0]                idim,
  input  wire  signed [13:0]         pan,
  input  wire  [18:0]                invz,
  output logic [12:0]                coord,
  output logic                       in_image
);
  import zpsag_pkg::*;

  localparam int D_W = V_W + 2;    // centered coordinate
  localparam int P_W = D_W + 20;   // scaled coordinate
  localparam int S_W = 32;         // Q16 source coordinate
  localparam int Q_SH = 16;

  // stage 1: center on the viewport
  logic signed [D_W-1:0] d1;
  logic                  in_view1;
  // stage 2: scale by inverse zoom
  logic signed [P_W-1:0] prod2;
  logic                  in_view2;

  logic signed [S_W-1:0] s;
  logic signed [S_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d1       <= $signed({2'b00, v}) - $signed({2'b00, vdim[V_W:1]});
      in_view1 <= {1'b0, v} < vdim;
    end
    if (en.s2) begin
      prod2    <= d1 * $signed({1'b0, invz});
      in_view2 <= in_view1;
    end
  end

  // stage 3: add half the image and the pan, then truncate toward zero
  always_comb begin
    s = S_W'(prod2) + $signed({4'b0000, idim, 15'b0}) + (S_W'(pan) <<< Q_SH);
    limit = $signed({3'b000, idim, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      coord    <= (s > 0) ? s[Q_SH+12:Q_SH] : 13'd0;
      in_image <= in_view2 && (idim != 13'd0) &&
                  (s > -(S_W'(1) <<< Q_SH)) && (s < limit);
    end
  end

endmodule

`default_nettype wire

>>> rtl/zpsag_index.sv
// linear index from column and row, black fill for pixels outside
`default_nettype none

module zpsag_index (
  input  wire                        clk,
  input  wire  zpsag_pkg::stage_en_t en,
  input  wire  [12:0]                cx,
  input  wire  [12:0]                cy,
  input  wire                        x_ok,
  input  wire                        y_ok,
  input  wire  [12:0]                image_width,
  output logic [23:0]                source_index,
  output logic                       source_valid
);
  import zpsag_pkg::*;

  logic [25:0] lin;

  assign lin = cy * image_width + 26'(cx);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      source_valid <= x_ok && y_ok;
      source_index <= (x_ok && y_ok) ? lin[23:0] : 24'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/zoom_pan_source_address_generator_top.sv
// top level of the zoom and pan source address generator
// Usage:
//   pixel channel: one beat carries a viewport column view_x and row view_y.
//   addr channel: one beat per pixel beat, in order, carrying source_index
//   (row times image width plus column) and source_valid (0 means black fill,
//   index then reads 0).
//   cfg channel: register index and data, always ready; write only while no
//   pixel is in flight. Register indexes beyond the list are ignored.
// Pipeline: the registered stages from pixel acceptance to the result beat are
//   center, scale multiply, translate and range check, index multiply-add.
// Throughput: one pixel per cycle unless the output stalls; each stage holds
//   one beat, advances when its successor is empty or moving; bubbles close up.
// Stall: addr_stall freezes the output register; pixel_stall rises only when
//   every stage is full and the output is stalled, so nothing is lost.
// Reset: rst (synchronous) empties the pipeline and loads the register
//   defaults: 456 by 190 viewport, no image, zoom 1, no pan.
`default_nettype none

module zoom_pan_source_address_generator_top (
  input  wire                               clk,
  input  wire                               rst,
  // configuration writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [zpsag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [zpsag_pkg::CFG_DATA_W-1:0]  cfg_data,
  // viewport pixels
  input  wire                               pixel_valid,
  output logic                              pixel_stall,
  input  wire  [8:0]                        view_x,
  input  wire  [7:0]                        view_y,
  // source addresses
  output logic                              addr_valid,
  input  wire                               addr_stall,
  output logic [23:0]                       source_index,
  output logic                              source_valid
);
  import zpsag_pkg::*;

  cfg_t      cfg;
  stage_en_t en;

  // valid bits travel alongside each stage
  logic v1;
  logic v2;
  logic v3;
  logic v4;

  logic [12:0] cx;
  logic [12:0] cy;
  logic        x_ok;
  logic        y_ok;

  zpsag_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en.s4 = !v4 || !addr_stall;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign pixel_stall = !en.s1;
  assign addr_valid  = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= pixel_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
    end
  end

  // horizontal axis
  zpsag_axis #(.V_W(9)) u_axis_x (
    .clk      (clk),
    .en       (en),
    .v        (view_x),
    .vdim     (cfg.view_width),
    .idim     (cfg.image_width),
    .pan      (cfg.pan_horizontal),
    .invz     (cfg.inverse_zoom),
    .coord    (cx),
    .in_image (x_ok)
  );

  // vertical axis
  zpsag_axis #(.V_W(8)) u_axis_y (
    .clk      (clk),
    .en       (en),
    .v        (view_y),
    .vdim     (cfg.view_height),
    .idim     (cfg.image_height),
    .pan      (cfg.pan_vertical),
    .invz     (cfg.inverse_zoom),
    .coord    (cy),
    .in_image (y_ok)
  );

  // row times width plus column into the output register
  zpsag_index u_index (
    .clk          (clk),
    .en           (en),
    .cx           (cx),
    .cy           (cy),
    .x_ok         (x_ok),
    .y_ok         (y_ok),
    .image_width  (cfg.image_width),
    .source_index (source_index),
    .source_valid (source_valid)
  );

endmodule

`default_nettype wire

>>> rtl/zpsag_checker.sv
// port-level checks of the address generator and their binding
`default_nettype none

`include "zoom_pan_source_address_generator_top_defines.svh"

module zpsag_checker (
  input wire        clk,
  input wire        rst,
  input wire        pixel_valid,
  input wire        pixel_stall,
  input wire        addr_valid,
  input wire        addr_stall,
  input wire [23:0] source_index,
  input wire        source_valid
);

  // black fill carries a zero index
  `ZPSAG_ASSERT(a_black_zero, addr_valid && !source_valid |-> source_index == 24'd0, "black beat with nonzero index")

  // a stalled beat holds
  `ZPSAG_ASSERT(a_hold, addr_valid && addr_stall |=> addr_valid && $stable(source_index) && $stable(source_valid), "stalled beat changed")

  // input backpressure only comes from a stalled full output
  `ZPSAG_ASSERT(a_stall_cause, pixel_stall |-> addr_valid && addr_stall, "pixel stall without output stall")

  // reset empties the pipeline
  `ZPSAG_ASSERT_ALWAYS(a_reset_empty, rst |=> !addr_valid, "result beat right after reset")

endmodule

bind zoom_pan_source_address_generator_top zpsag_checker u_checker (.*);

`default_nettype wire
